@@ hw/rtl/stdp_pkg.sv @@
// Shared types and constants for the scan timer with on-delay, pulse and capture modes.
// No dependencies; imported by every module of the block.
package stdp_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int CFG_IDX_W      = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME_MS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME_MS  = 2'd2;

	// Timer mode codes
	localparam logic [1:0] MODE_ONESHOT = 2'd0;
	localparam logic [1:0] MODE_PULSE   = 2'd1;
	localparam logic [1:0] MODE_CAPTURE = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] now_ms;
		logic               enable_cmd;
	} in_item_t;

	typedef struct packed {
		logic               timer_running;
		logic               timer_done;
		logic [FIELD_W-1:0] elapsed_out;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         timer_mode;
		logic [FIELD_W-1:0] off_time_ms;
		logic [FIELD_W-1:0] on_time_ms;
	} cfg_t;

endpackage

@@ hw/rtl/scan_timer_delay_pulse.sv @@
// Top level of the scan timer: input register, timer core and result register.
// Depends on stdp_pkg, stdp_cfg and stdp_core.
//
// Usage:
//   Each input transaction on in_valid/in_ready is one scan: the current
//   millisecond time and the enable command. Each scan yields exactly one
//   result transaction on out_valid/out_ready carrying the running flag,
//   the done level and the elapsed time after that scan's update.
//   Configuration is written through cfg_we/cfg_index/cfg_data with no
//   handshake; write it only while no scan is in flight.
//   Path: a scan accepted at one edge sits in the input register; when the
//   result register is free or draining it is applied to the timer state,
//   and its result is captured in the result register and offered on out_valid.
//   Throughput: one scan per cycle while the receiver does not stall, set by the
//   single subtract-and-compare feedback through the timer state register.
//   The input register keeps accepting while a finished result waits; when
//   the receiver stalls, the result register and then the input register
//   hold, and in_ready falls only once both are full.
//   Reset clears the timer state, all configuration registers and both
//   valid flags.
module scan_timer_delay_pulse
	import stdp_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t out_q;
	logic      out_valid_q;
	logic      advance;

	stdp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the held scan when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	stdp_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hw/rtl/stdp_cfg.sv @@
// Configuration register file for the scan timer.
// Depends on stdp_pkg for register indexes and the cfg_t struct.
module stdp_cfg
	import stdp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMER_MODE:  cfg_q.timer_mode  <= cfg_data[1:0];
				CFG_OFF_TIME_MS: cfg_q.off_time_ms <= cfg_data;
				CFG_ON_TIME_MS:  cfg_q.on_time_ms  <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/stdp_core.sv @@
// Timer state and per-scan update: one subtract and compare against the limits.
// Depends on stdp_pkg for item structs, cfg_t and mode codes.
module stdp_core
	import stdp_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	logic                  running_q, done_q;
	logic [TIME_WIDTH-1:0] start_q, elapsed_q;

	logic                  running_d, done_d;
	logic [TIME_WIDTH-1:0] start_d, elapsed_d;
	logic [TIME_WIDTH-1:0] now_w, start_eff, diff;
	logic [63:0]           now_ext, diff_ext, elapsed_ext;
	logic                  off_hit, on_hit;

	assign now_ext   = {32'd0, item.now_ms};
	assign now_w     = now_ext[TIME_WIDTH-1:0];
	assign start_eff = running_q ? start_q : now_w;
	assign diff      = now_w - start_eff;
	// Zero-extend the wrapped difference to compare with the full limit
	assign diff_ext  = 64'(diff);
	assign off_hit   = diff_ext >= {32'd0, cfg.off_time_ms};
	assign on_hit    = diff_ext >= {32'd0, cfg.on_time_ms};

	always_comb begin
		running_d = running_q;
		done_d    = done_q;
		start_d   = start_q;
		elapsed_d = elapsed_q;
		if (!item.enable_cmd) begin
			running_d = 1'b0;
			done_d    = 1'b0;
		end else begin
			running_d = 1'b1;
			start_d   = start_eff;
			case (cfg.timer_mode)
				MODE_ONESHOT: begin
					if (!done_q) begin
						elapsed_d = diff;
						done_d    = off_hit;
					end
				end
				MODE_PULSE: begin
					elapsed_d = diff;
					// toggle the level and restart timing from this scan
					if ((!done_q && off_hit) || (done_q && on_hit)) begin
						done_d    = !done_q;
						start_d   = now_w;
						elapsed_d = '0;
					end
				end
				MODE_CAPTURE: elapsed_d = diff;
				default: ; // unused mode: start only
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			start_q   <= '0;
			elapsed_q <= '0;
		end else if (step) begin
			running_q <= running_d;
			done_q    <= done_d;
			start_q   <= start_d;
			elapsed_q <= elapsed_d;
		end
	end

	assign elapsed_ext          = 64'(elapsed_d);
	assign result.timer_running = running_d;
	assign result.timer_done    = done_d;
	assign result.elapsed_out   = elapsed_ext[FIELD_W-1:0];

endmodule
